// ----- hdl/uct_pkg.sv -----
// uct_pkg: codes, byte constants and controller/datapath command and status types
// for the uri component tokenizer. No dependencies.
`timescale 1ns / 1ps

package uct_pkg;

   localparam int BUFFER_BYTES_DEFAULT = 64;

   typedef logic [2:0] kind_type;
   typedef logic [2:0] code_type;
   typedef logic [2:0] phase_type;
   typedef logic [1:0] tok_sel_type;
   typedef logic [1:0] fill_op_type;
   typedef logic [1:0] wr_sel_type;

   // token kinds
   localparam kind_type KIND_STATUS   = 3'd0;
   localparam kind_type KIND_SCHEME   = 3'd1;
   localparam kind_type KIND_AUTH     = 3'd2;
   localparam kind_type KIND_HOST     = 3'd3;
   localparam kind_type KIND_PORT     = 3'd4;
   localparam kind_type KIND_PATH     = 3'd5;
   localparam kind_type KIND_QUERY    = 3'd6;
   localparam kind_type KIND_FRAGMENT = 3'd7;

   // status codes
   localparam code_type ST_OK            = 3'd0;
   localparam code_type ST_DONE          = 3'd1;
   localparam code_type ST_NO_SCHEME     = 3'd2;
   localparam code_type ST_HOST_LONG     = 3'd3;
   localparam code_type ST_DUP_AUTH      = 3'd4;
   localparam code_type ST_PATH_LONG     = 3'd5;
   localparam code_type ST_QUERY_LONG    = 3'd6;
   localparam code_type ST_FRAGMENT_LONG = 3'd7;

   // parse phases
   localparam phase_type PH_SCHEME       = 3'd0;
   localparam phase_type PH_AFTER_SCHEME = 3'd1;
   localparam phase_type PH_AFTER_AUTH   = 3'd2;
   localparam phase_type PH_PATH         = 3'd3;
   localparam phase_type PH_QUERY        = 3'd4;
   localparam phase_type PH_FRAGMENT     = 3'd5;

   // delimiters
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_HASH  = 8'h23;

   // token replay selection
   localparam tok_sel_type TS_WHOLE  = 2'd0;
   localparam tok_sel_type TS_SCHEME = 2'd1;
   localparam tok_sel_type TS_HOST   = 2'd2;
   localparam tok_sel_type TS_PORT   = 2'd3;

   // fill count update
   localparam fill_op_type FO_HOLD  = 2'd0;
   localparam fill_op_type FO_INC   = 2'd1;
   localparam fill_op_type FO_CLEAR = 2'd2;
   localparam fill_op_type FO_ONE   = 2'd3;

   // buffer write selection
   localparam wr_sel_type WR_NONE  = 2'd0;
   localparam wr_sel_type WR_BYTE  = 2'd1;
   localparam wr_sel_type WR_SLASH = 2'd2;

   typedef struct packed {
      logic        latch;
      wr_sel_type  wr_sel;
      fill_op_type fill_op;
      logic        track_colon;
      logic        tok_load;
      tok_sel_type tok_sel;
      logic        out_token;
      logic        out_status;
      kind_type    kind;
      code_type    status;
   } cmd_type;

   typedef struct packed {
      logic action;
      logic is_slash;
      logic is_at;
      logic is_quest;
      logic is_hash;
      logic fill_zero;
      logic full_next;
      logic scheme_hit;
      logic split;
      logic item_last;
      logic out_free;
   } stat_type;

endpackage

// ----- hdl/uct_if.sv -----
// uct_req_if and uct_rsp_if: valid/ready channels for input bytes and result items.
// Depends on nothing.
`timescale 1ns / 1ps

interface uct_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] data_byte;

   modport source (output valid, output action, output data_byte, input ready);
   modport sink (input valid, input action, input data_byte, output ready);
endinterface

interface uct_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] token_kind;
   logic [7:0] token_byte;
   logic       byte_valid;
   logic       token_end;
   logic [2:0] status;
   logic       last;

   modport source (output valid, output token_kind, output token_byte, output byte_valid,
                   output token_end, output status, output last, input ready);
   modport sink (input valid, input token_kind, input token_byte, input byte_valid,
                 input token_end, input status, input last, output ready);
endinterface

// ----- hdl/uct_datapath.sv -----
// uct_datapath: component buffer memory, fill count, colon tracker, replay pointers
// and the result register. Depends on uct_pkg.
`timescale 1ns / 1ps

module uct_datapath #(
   parameter int BUFFER_BYTES = uct_pkg::BUFFER_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  uct_pkg::cmd_type  cmd,
   output uct_pkg::stat_type stat,
   input  logic              req_action,
   input  logic [7:0]        req_data_byte,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [2:0]        rsp_token_kind,
   output logic [7:0]        rsp_token_byte,
   output logic              rsp_byte_valid,
   output logic              rsp_token_end,
   output logic [2:0]        rsp_status,
   output logic              rsp_last
);
   import uct_pkg::*;

   localparam int AW = $clog2(BUFFER_BYTES);
   localparam int CW = $clog2(BUFFER_BYTES + 1);
   localparam logic [CW-1:0] FullCount = CW'(BUFFER_BYTES);

   logic [7:0]    buf_mem [BUFFER_BYTES];
   logic [7:0]    rd_data_ff;

   logic          action_ff;
   logic [7:0]    byte_ff;
   logic [CW-1:0] fill_ff, fill_in;
   logic          colon_seen_ff, colon_seen_in;
   logic [AW-1:0] colon_pos_ff, colon_pos_in;
   logic [7:0]    prev1_ff, prev1_in, prev2_ff, prev2_in;
   logic [CW-1:0] ptr_ff, ptr_in, stop_ff, stop_in, hp_end_ff, hp_end_in;
   logic [AW-1:0] hp_pos_ff, hp_pos_in;
   logic          split_ff, split_in;

   logic          valid_ff, valid_in;
   kind_type      kind_ff, kind_in;
   logic [7:0]    tbyte_ff, tbyte_in;
   logic          bvalid_ff, bvalid_in;
   logic          tend_ff, tend_in;
   code_type      status_ff, status_in;
   logic          last_ff, last_in;

   logic [CW-1:0] fill_inc, ptr_inc;
   logic          item_empty, item_last, out_free;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;

   assign fill_inc   = fill_ff + 1'b1;
   assign ptr_inc    = ptr_ff + 1'b1;
   assign item_empty = (ptr_ff == stop_ff);
   assign item_last  = item_empty || (ptr_inc == stop_ff);
   assign out_free   = !valid_ff || rsp_ready;

   always_comb begin
      stat.action     = action_ff;
      stat.is_slash   = (byte_ff == CH_SLASH);
      stat.is_at      = (byte_ff == CH_AT);
      stat.is_quest   = (byte_ff == CH_QUEST);
      stat.is_hash    = (byte_ff == CH_HASH);
      stat.fill_zero  = (fill_ff == '0);
      stat.full_next  = (fill_inc >= FullCount);
      stat.scheme_hit = (fill_ff >= CW'(3)) && (prev2_ff == CH_COLON)
                        && (prev1_ff == CH_SLASH) && (byte_ff == CH_SLASH);
      stat.split      = split_ff;
      stat.item_last  = item_last;
      stat.out_free   = out_free;
   end

   // buffer write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = fill_ff[AW-1:0];
      wr_data = byte_ff;
      unique case (cmd.wr_sel)
         WR_BYTE: begin
            wr_en = 1'b1;
         end
         WR_SLASH: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = CH_SLASH;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         buf_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= buf_mem[ptr_ff[AW-1:0]];
   end

   // fill count, colon tracker and last two appended bytes
   always_comb begin
      unique case (cmd.fill_op)
         FO_HOLD:  fill_in = fill_ff;
         FO_INC:   fill_in = fill_inc;
         FO_CLEAR: fill_in = '0;
         FO_ONE:   fill_in = CW'(1);
      endcase

      colon_seen_in = colon_seen_ff;
      colon_pos_in  = colon_pos_ff;
      if (cmd.track_colon && (byte_ff == CH_COLON) && !colon_seen_ff) begin
         colon_seen_in = 1'b1;
         colon_pos_in  = fill_ff[AW-1:0];
      end
      if ((cmd.fill_op == FO_CLEAR) || (cmd.fill_op == FO_ONE)) begin
         colon_seen_in = 1'b0;
      end

      prev1_in = prev1_ff;
      prev2_in = prev2_ff;
      if (cmd.wr_sel == WR_BYTE) begin
         prev1_in = byte_ff;
         prev2_in = prev1_ff;
      end
   end

   // replay pointers
   always_comb begin
      ptr_in    = ptr_ff;
      stop_in   = stop_ff;
      hp_end_in = hp_end_ff;
      hp_pos_in = hp_pos_ff;
      split_in  = split_ff;
      if (cmd.out_token) begin
         ptr_in = ptr_inc;
      end
      if (cmd.tok_load) begin
         unique case (cmd.tok_sel)
            TS_WHOLE: begin
               ptr_in  = '0;
               stop_in = fill_ff;
            end
            TS_SCHEME: begin
               ptr_in  = '0;
               stop_in = fill_ff - CW'(2);
            end
            TS_HOST: begin
               ptr_in    = '0;
               stop_in   = colon_seen_ff ? CW'(colon_pos_ff) : fill_ff;
               split_in  = colon_seen_ff;
               hp_pos_in = colon_pos_ff;
               hp_end_in = fill_ff;
            end
            TS_PORT: begin
               ptr_in  = CW'(hp_pos_ff) + 1'b1;
               stop_in = hp_end_ff;
            end
         endcase
      end
   end

   // result register
   always_comb begin
      valid_in  = valid_ff;
      kind_in   = kind_ff;
      tbyte_in  = tbyte_ff;
      bvalid_in = bvalid_ff;
      tend_in   = tend_ff;
      status_in = status_ff;
      last_in   = last_ff;
      if (rsp_ready) begin
         valid_in = 1'b0;
      end
      if (cmd.out_token) begin
         valid_in  = 1'b1;
         kind_in   = cmd.kind;
         tbyte_in  = item_empty ? 8'h00 : rd_data_ff;
         bvalid_in = !item_empty;
         tend_in   = item_last;
         status_in = ST_OK;
         last_in   = 1'b0;
      end else if (cmd.out_status) begin
         valid_in  = 1'b1;
         kind_in   = KIND_STATUS;
         tbyte_in  = 8'h00;
         bvalid_in = 1'b0;
         tend_in   = 1'b0;
         status_in = cmd.status;
         last_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         colon_seen_ff <= 1'b0;
         valid_ff      <= 1'b0;
      end else begin
         fill_ff       <= fill_in;
         colon_seen_ff <= colon_seen_in;
         valid_ff      <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         action_ff <= req_action;
         byte_ff   <= req_data_byte;
      end
      colon_pos_ff <= colon_pos_in;
      prev1_ff     <= prev1_in;
      prev2_ff     <= prev2_in;
      ptr_ff       <= ptr_in;
      stop_ff      <= stop_in;
      hp_end_ff    <= hp_end_in;
      hp_pos_ff    <= hp_pos_in;
      split_ff     <= split_in;
      kind_ff      <= kind_in;
      tbyte_ff     <= tbyte_in;
      bvalid_ff    <= bvalid_in;
      tend_ff      <= tend_in;
      status_ff    <= status_in;
      last_ff      <= last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_token_kind = kind_ff;
   assign rsp_token_byte = tbyte_ff;
   assign rsp_byte_valid = bvalid_ff;
   assign rsp_token_end  = tend_ff;
   assign rsp_status     = status_ff;
   assign rsp_last       = last_ff;

endmodule

// ----- hdl/uct_controller.sv -----
// uct_controller: parse phase, sticky error and the sequencing of token replay
// and status transfers. Depends on uct_pkg.
`timescale 1ns / 1ps

module uct_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  uct_pkg::stat_type stat,
   output uct_pkg::cmd_type  cmd
);
   import uct_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECIDE = 3'd1;
   localparam logic [2:0] S_READ   = 3'd2;
   localparam logic [2:0] S_EMIT   = 3'd3;
   localparam logic [2:0] S_SLASH  = 3'd4;
   localparam logic [2:0] S_STATUS = 3'd5;

   logic [2:0] state_ff, state_in;
   phase_type  phase_ff, phase_in;
   logic       ended_ff, ended_in;
   code_type   error_ff, error_in;
   kind_type   kind_ff, kind_in;
   logic       host_ff, host_in;
   logic       slash_ff, slash_in;
   logic       tok_go;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      ended_in = ended_ff;
      error_in = error_ff;
      kind_in  = kind_ff;
      host_in  = host_ff;
      slash_in = slash_ff;
      tok_go   = 1'b0;
      cmd      = '0;
      cmd.kind = kind_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DECIDE;
            end
         end

         S_DECIDE: begin
            if (error_ff != ST_OK) begin
               error_in = error_ff;
            end else if (ended_ff) begin
               error_in = ST_DONE;
            end else if (stat.action) begin
               ended_in = 1'b1;
               if (!stat.fill_zero) begin
                  tok_go      = 1'b1;
                  cmd.tok_sel = TS_WHOLE;
                  unique case (phase_ff)
                     PH_SCHEME: kind_in = KIND_SCHEME;
                     PH_AFTER_SCHEME, PH_AFTER_AUTH: begin
                        kind_in     = KIND_HOST;
                        cmd.tok_sel = TS_HOST;
                        host_in     = 1'b1;
                     end
                     PH_PATH:     kind_in = KIND_PATH;
                     PH_QUERY:    kind_in = KIND_QUERY;
                     PH_FRAGMENT: kind_in = KIND_FRAGMENT;
                     default:     tok_go  = 1'b0;
                  endcase
               end
            end else begin
               cmd.wr_sel  = WR_BYTE;
               cmd.fill_op = FO_INC;
               unique case (phase_ff)
                  PH_SCHEME: begin
                     if (stat.scheme_hit) begin
                        tok_go      = 1'b1;
                        cmd.tok_sel = TS_SCHEME;
                        kind_in     = KIND_SCHEME;
                        cmd.fill_op = FO_CLEAR;
                        phase_in    = PH_AFTER_SCHEME;
                     end else if (stat.full_next) begin
                        error_in = ST_NO_SCHEME;
                     end
                  end
                  PH_AFTER_SCHEME, PH_AFTER_AUTH: begin
                     cmd.track_colon = 1'b1;
                     priority if (stat.is_slash) begin
                        cmd.fill_op = FO_HOLD;
                        slash_in    = 1'b1;
                        phase_in    = PH_PATH;
                        if (!stat.fill_zero) begin
                           tok_go      = 1'b1;
                           cmd.tok_sel = TS_HOST;
                           kind_in     = KIND_HOST;
                           host_in     = 1'b1;
                        end
                     end else if (stat.is_at) begin
                        if (phase_ff == PH_AFTER_AUTH) begin
                           error_in = ST_DUP_AUTH;
                        end else begin
                           tok_go      = 1'b1;
                           cmd.tok_sel = TS_WHOLE;
                           kind_in     = KIND_AUTH;
                           cmd.fill_op = FO_CLEAR;
                           phase_in    = PH_AFTER_AUTH;
                        end
                     end else if (stat.full_next) begin
                        error_in = ST_HOST_LONG;
                     end
                  end
                  PH_PATH: begin
                     if (stat.is_quest) begin
                        tok_go      = 1'b1;
                        cmd.tok_sel = TS_WHOLE;
                        kind_in     = KIND_PATH;
                        cmd.fill_op = FO_CLEAR;
                        phase_in    = PH_QUERY;
                     end else if (stat.full_next) begin
                        error_in = ST_PATH_LONG;
                     end
                  end
                  PH_QUERY: begin
                     if (stat.is_hash) begin
                        tok_go      = 1'b1;
                        cmd.tok_sel = TS_WHOLE;
                        kind_in     = KIND_QUERY;
                        cmd.fill_op = FO_CLEAR;
                        phase_in    = PH_FRAGMENT;
                     end else if (stat.full_next) begin
                        error_in = ST_QUERY_LONG;
                     end
                  end
                  PH_FRAGMENT: begin
                     if (stat.full_next) begin
                        error_in = ST_FRAGMENT_LONG;
                     end
                  end
                  default: begin
                     cmd.wr_sel  = WR_NONE;
                     cmd.fill_op = FO_HOLD;
                  end
               endcase
            end

            cmd.tok_load = tok_go;
            priority if (tok_go) begin
               state_in = S_READ;
            end else if (slash_in) begin
               state_in = S_SLASH;
            end else if (stat.out_free) begin
               cmd.out_status = 1'b1;
               cmd.status     = error_in;
               state_in       = S_IDLE;
            end else begin
               state_in = S_STATUS;
            end
         end

         S_READ: begin
            state_in = S_EMIT;
         end

         S_EMIT: begin
            if (stat.out_free) begin
               cmd.out_token = 1'b1;
               if (stat.item_last) begin
                  host_in = 1'b0;
                  priority if (host_ff && stat.split) begin
                     cmd.tok_load = 1'b1;
                     cmd.tok_sel  = TS_PORT;
                     kind_in      = KIND_PORT;
                     state_in     = S_READ;
                  end else if (slash_ff) begin
                     state_in = S_SLASH;
                  end else begin
                     state_in = S_STATUS;
                  end
               end else begin
                  state_in = S_READ;
               end
            end
         end

         S_SLASH: begin
            cmd.wr_sel  = WR_SLASH;
            cmd.fill_op = FO_ONE;
            slash_in    = 1'b0;
            state_in    = S_STATUS;
         end

         S_STATUS: begin
            if (stat.out_free) begin
               cmd.out_status = 1'b1;
               cmd.status     = error_ff;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_SCHEME;
         ended_ff <= 1'b0;
         error_ff <= ST_OK;
         kind_ff  <= KIND_STATUS;
         host_ff  <= 1'b0;
         slash_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         ended_ff <= ended_in;
         error_ff <= error_in;
         kind_ff  <= kind_in;
         host_ff  <= host_in;
         slash_ff <= slash_in;
      end
   end

endmodule

// ----- hdl/uri_component_tokenizer.sv -----
// channel   dir   handshake          payload
// req_if    in    valid/ready        action, data_byte
// rsp_if    out   valid/ready        token_kind, token_byte, byte_valid, token_end,
//                                    status, last
// a buffered-only byte: accept, then decide and load the status once rsp_if is free
// each token byte: buffer memory read (registered) in S_READ, then result load in S_EMIT
// after a token the status is loaded in its own state, S_STATUS
// the '/' opening a path adds S_SLASH to rewrite buffer entry zero, then the status
// a stalled rsp_if holds the result register; req_if reopens once the status is loaded
// reset is synchronous and needs no clearing pass
// Depends on uct_pkg, uct_if, uct_controller and uct_datapath.
`timescale 1ns / 1ps

module uri_component_tokenizer #(
   parameter int BUFFER_BYTES = uct_pkg::BUFFER_BYTES_DEFAULT
) (
   input logic      clock,
   input logic      reset,
   uct_req_if.sink  req_if,
   uct_rsp_if.source rsp_if
);
   import uct_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   uct_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   uct_datapath #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_action     (req_if.action),
      .req_data_byte  (req_if.data_byte),
      .rsp_ready      (rsp_if.ready),
      .rsp_valid      (rsp_if.valid),
      .rsp_token_kind (rsp_if.token_kind),
      .rsp_token_byte (rsp_if.token_byte),
      .rsp_byte_valid (rsp_if.byte_valid),
      .rsp_token_end  (rsp_if.token_end),
      .rsp_status     (rsp_if.status),
      .rsp_last       (rsp_if.last)
   );

endmodule

// ----- hdl/uct_checker.sv -----
// uct_checker: port-level checks on transfers, status stickiness and outstanding
// inputs, bound to uri_component_tokenizer. Depends on uct_pkg.
`timescale 1ns / 1ps

module uct_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_token_kind,
   input logic [7:0] rsp_token_byte,
   input logic       rsp_byte_valid,
   input logic       rsp_token_end,
   input logic [2:0] rsp_status,
   input logic       rsp_last
);
   import uct_pkg::*;

   logic       req_xfer, last_xfer;
   logic       err_seen_ff, err_seen_in;
   logic [1:0] pending_ff, pending_in;

   assign req_xfer  = req_valid && req_ready;
   assign last_xfer = rsp_valid && rsp_ready && rsp_last;

   always_comb begin
      err_seen_in = err_seen_ff || (last_xfer && (rsp_status != ST_OK));
      pending_in  = pending_ff + {1'b0, req_xfer} - {1'b0, last_xfer};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_seen_ff <= 1'b0;
         pending_ff  <= '0;
      end else begin
         err_seen_ff <= err_seen_in;
         pending_ff  <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_token_kind, rsp_token_byte,
         rsp_byte_valid, rsp_token_end, rsp_status, rsp_last}))
      else $error("result changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_ready)
      else $error("input taken while previous input still in work");

   a_status_has_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> pending_ff != 2'd0)
      else $error("status without an input");

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("too many inputs outstanding");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last && err_seen_ff |-> rsp_status != ST_OK)
      else $error("error code cleared");

endmodule

bind uri_component_tokenizer uct_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_token_kind (rsp_if.token_kind),
   .rsp_token_byte (rsp_if.token_byte),
   .rsp_byte_valid (rsp_if.byte_valid),
   .rsp_token_end  (rsp_if.token_end),
   .rsp_status     (rsp_if.status),
   .rsp_last       (rsp_if.last)
);
